// ----- sv/gpta_pkg.sv -----
package gpta_pkg;

   localparam int COORD_W   = 12;
   localparam int DIST_W    = 13;
   localparam int WIN_REG_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;
   localparam int REQ_DAT_W = 24;
   localparam int RSP_DAT_W = 32;

   localparam logic [DIST_W-1:0]    ANCHOR_SLACK     = 13'd5;
   localparam logic [DIST_W-1:0]    MAX_DIST_RESET   = 13'd20;
   localparam logic [WIN_REG_W-1:0] AVG_WINDOW_RESET = 5'd4;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_DIST   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_AVG_WINDOW = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
   } mem_ctl_type;

endpackage

// ----- sv/gated_point_tracker_average.sv -----
// When fewer points than the window are stored, the result is the last accepted point;
// otherwise it is the mean of the last W stored points for a window of W points.
// One item at a time: the next input transaction is taken only after the last result
// has entered the response register, which waits while a previous result is unaccepted.
// The mean comes from a walk over the history memory (one read per point) and a 12-step divider.
// Reset is synchronous and active high; it clears the track, the ring pointers and the
// registers to their defaults. History entries are not cleared.
module gated_point_tracker_average #(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: point_x [11:0], point_y [23:12]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gpta_pkg::REQ_DAT_W-1:0]      req_tdata,
   // tdata: accepted [0], anchor_reset [1], smooth_x [13:2], smooth_y [25:14], zeros above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gpta_pkg::RSP_DAT_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gpta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpta_pkg::CSR_DAT_W-1:0]      csr_data
);

   localparam int CW     = gpta_pkg::COORD_W;
   localparam int DW     = gpta_pkg::DIST_W;
   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = CW + CNT_W;

   gpta_pkg::state_type state_ff, state_in;

   logic [DW-1:0]                    max_dist_ff;
   logic [gpta_pkg::WIN_REG_W-1:0]   avg_window_ff;

   logic              has_point_ff, has_point_in;
   logic [CW-1:0]     last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [CW-1:0]     anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  win_ff, win_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]  issue_left_ff, issue_left_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CW-1:0]     pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic              acc_ff, acc_in, anc_ff, anc_in;
   logic [CW-1:0]     res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [gpta_pkg::RSP_DAT_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]     req_x, req_y;
   logic [CW-1:0]     dlx, dly, dax, day;
   logic [DW-1:0]     dist_last, dist_anchor;
   logic [CNT_W-1:0]  win_calc;
   logic              req_fire;
   logic              div_start, div_done_x, div_done_y;
   logic [CW-1:0]     quot_x, quot_y;
   logic [2*CW-1:0]   rd_data;
   gpta_pkg::mem_ctl_type mem_ctl;

   assign req_x    = req_tdata[CW-1:0];
   assign req_y    = req_tdata[2*CW-1:CW];
   assign req_fire = req_tvalid && req_tready;

   assign dlx = (req_x > last_x_ff) ? req_x - last_x_ff : last_x_ff - req_x;
   assign dly = (req_y > last_y_ff) ? req_y - last_y_ff : last_y_ff - req_y;
   assign dax = (req_x > anchor_x_ff) ? req_x - anchor_x_ff : anchor_x_ff - req_x;
   assign day = (req_y > anchor_y_ff) ? req_y - anchor_y_ff : anchor_y_ff - req_y;
   assign dist_last   = DW'(dlx) + DW'(dly);
   assign dist_anchor = DW'(dax) + DW'(day);

   always_comb begin
      if (avg_window_ff == '0) begin
         win_calc = CNT_W'(1);
      end else if (32'(avg_window_ff) > 32'(HISTORY_DEPTH)) begin
         win_calc = CNT_W'(HISTORY_DEPTH);
      end else begin
         win_calc = CNT_W'(avg_window_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff   <= gpta_pkg::MAX_DIST_RESET;
         avg_window_ff <= gpta_pkg::AVG_WINDOW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            gpta_pkg::REG_MAX_DIST:   max_dist_ff   <= csr_data;
            gpta_pkg::REG_AVG_WINDOW: avg_window_ff <= csr_data[gpta_pkg::WIN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      has_point_in  = has_point_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      anchor_x_in   = anchor_x_ff;
      anchor_y_in   = anchor_y_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      win_in        = win_ff;
      rd_slot_in    = rd_slot_ff;
      issue_left_in = issue_left_ff;
      rd_pend_in    = 1'b0;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      acc_in        = acc_ff;
      anc_in        = anc_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_ctl       = '0;
      div_start     = 1'b0;

      unique case (state_ff)
         gpta_pkg::ST_IDLE: begin
            if (req_fire) begin
               pt_x_in  = req_x;
               pt_y_in  = req_y;
               if (!has_point_ff) begin
                  acc_in = 1'b1;
                  anc_in = 1'b1;
               end else begin
                  acc_in = (dist_last < max_dist_ff);
                  anc_in = (dist_last < max_dist_ff) && (dist_anchor > gpta_pkg::ANCHOR_SLACK);
               end
               state_in = gpta_pkg::ST_UPDATE;
            end
         end
         gpta_pkg::ST_UPDATE: begin
            win_in = win_calc;
            if (acc_ff) begin
               mem_ctl.wr_en = 1'b1;
               has_point_in  = 1'b1;
               last_x_in     = pt_x_ff;
               last_y_in     = pt_y_ff;
               slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
               if (count_ff != CNT_W'(HISTORY_DEPTH)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (anc_ff) begin
                  anchor_x_in = pt_x_ff;
                  anchor_y_in = pt_y_ff;
               end
            end
            if (count_in < win_calc) begin
               res_x_in = last_x_in;
               res_y_in = last_y_in;
               state_in = gpta_pkg::ST_DONE;
            end else begin
               rd_slot_in    = (slot_in == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : slot_in - SLOT_W'(1);
               issue_left_in = win_calc;
               sum_x_in      = '0;
               sum_y_in      = '0;
               state_in      = gpta_pkg::ST_SUM;
            end
         end
         gpta_pkg::ST_SUM: begin
            if (issue_left_ff != '0) begin
               mem_ctl.rd_en = 1'b1;
               rd_pend_in    = 1'b1;
               issue_left_in = issue_left_ff - CNT_W'(1);
               rd_slot_in    = (rd_slot_ff == '0) ? SLOT_W'(HISTORY_DEPTH - 1)
                                                  : rd_slot_ff - SLOT_W'(1);
            end
            if (rd_pend_ff) begin
               sum_x_in = sum_x_ff + SUM_W'(rd_data[CW-1:0]);
               sum_y_in = sum_y_ff + SUM_W'(rd_data[2*CW-1:CW]);
            end
            if (issue_left_ff == '0 && !rd_pend_ff) begin
               div_start = 1'b1;
               state_in  = gpta_pkg::ST_DIV;
            end
         end
         gpta_pkg::ST_DIV: begin
            if (div_done_x) begin
               res_x_in = quot_x;
               res_y_in = quot_y;
               state_in = gpta_pkg::ST_DONE;
            end
         end
         gpta_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, res_y_ff, res_x_ff, anc_ff, acc_ff};
               state_in     = gpta_pkg::ST_IDLE;
            end
         end
         default: state_in = gpta_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gpta_pkg::ST_IDLE;
         has_point_ff  <= 1'b0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         anchor_x_ff   <= '0;
         anchor_y_ff   <= '0;
         slot_ff       <= '0;
         count_ff      <= '0;
         issue_left_ff <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         has_point_ff  <= has_point_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         anchor_x_ff   <= anchor_x_in;
         anchor_y_ff   <= anchor_y_in;
         slot_ff       <= slot_in;
         count_ff      <= count_in;
         issue_left_ff <= issue_left_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      win_ff      <= win_in;
      rd_slot_ff  <= rd_slot_in;
      sum_x_ff    <= sum_x_in;
      sum_y_ff    <= sum_y_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      acc_ff      <= acc_in;
      anc_ff      <= anc_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   gpta_hist_mem #(
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (SLOT_W),
      .DATA_W (2 * CW)
   ) u_hist_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (slot_ff),
      .wr_data ({pt_y_ff, pt_x_ff}),
      .rd_addr (rd_slot_ff),
      .rd_data (rd_data)
   );

   gpta_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_x_ff),
      .divisor  (win_ff),
      .done     (div_done_x),
      .quotient (quot_x)
   );

   gpta_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_y_ff),
      .divisor  (win_ff),
      .done     (div_done_y),
      .quotient (quot_y)
   );

   assign req_tready = (state_ff == gpta_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(HISTORY_DEPTH))
      else $error("history fill count exceeds the ring depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gpta_pkg::ST_DONE && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == gpta_pkg::ST_DONE))
      else $error("pending result would be overwritten");

   a_anchor_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[1] && !rsp_data_ff[0]))
      else $error("anchor moved on a rejected point");

   a_div_in_phase: assert property (@(posedge clock) disable iff (reset)
      (div_done_x || div_done_y) |-> (div_done_x == div_done_y && state_ff == gpta_pkg::ST_DIV))
      else $error("divider finished outside the divide phase");

   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> !mem_ctl.wr_en && state_ff == gpta_pkg::ST_SUM)
      else $error("history read overlaps a write");

endmodule

// ----- sv/gpta_hist_mem.sv -----
module gpta_hist_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 24
) (
   input  logic                 clock,
   input  gpta_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [DATA_W-1:0]    rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gpta_div.sv -----
module gpta_div #(
   parameter int SUM_W = 17,
   parameter int DIV_W = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_W-1:0]               dividend,
   input  logic [DIV_W-1:0]               divisor,
   output logic                           done,
   output logic [gpta_pkg::COORD_W-1:0]   quotient
);

   localparam int QW     = gpta_pkg::COORD_W;
   localparam int STEP_W = $clog2(QW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  dv_ff, dv_in;
   logic [QW-1:0]     q_ff, q_in;
   logic              ge;

   assign ge = (rem_ff >= dv_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(QW - 1);
         rem_in  = dividend;
         dv_in   = SUM_W'(divisor) << (QW - 1);
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dv_ff;
         end
         q_in  = {q_ff[QW-2:0], ge};
         dv_in = dv_ff >> 1;
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- bench/tb_gated_point_tracker_average.sv -----
module tb_gated_point_tracker_average;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W   = gpta_pkg::COORD_W;
   localparam int DIST_W    = gpta_pkg::DIST_W;
   localparam int WIN_REG_W = gpta_pkg::WIN_REG_W;
   localparam int CSR_IDX_W = gpta_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W = gpta_pkg::CSR_DAT_W;
   localparam int REQ_DAT_W = gpta_pkg::REQ_DAT_W;
   localparam int RSP_DAT_W = gpta_pkg::RSP_DAT_W;

   localparam int HISTORY_DEPTH  = 16;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int SETTLE_CYCLES  = 4;
   localparam int SEGMENT_POINTS = 96;

   typedef struct packed {
      logic               accepted;
      logic               anchor_reset;
      logic [COORD_W-1:0] smooth_x;
      logic [COORD_W-1:0] smooth_y;
   } track_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_DAT_W-1:0] req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_DAT_W-1:0] rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // Shadow copy of the tracker state and its registers.
   logic                     has_point;
   logic [COORD_W-1:0]       last_x;
   logic [COORD_W-1:0]       last_y;
   logic [COORD_W-1:0]       anchor_x;
   logic [COORD_W-1:0]       anchor_y;
   logic [2*COORD_W-1:0]     history [HISTORY_DEPTH];
   int                       write_slot;
   int                       stored_count;
   logic [DIST_W-1:0]        max_dist;
   logic [WIN_REG_W-1:0]     avg_window;

   track_result_type expected_tracks[$];
   int               error_count;
   int               cycle_count;
   int               send_idle_pct;
   int               recv_stall_pct;

   gated_point_tracker_average #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_tracks.size());
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      track_result_type seen;
      track_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.accepted     = rsp_tdata[0];
         seen.anchor_reset = rsp_tdata[1];
         seen.smooth_x     = rsp_tdata[2 +: COORD_W];
         seen.smooth_y     = rsp_tdata[2 + COORD_W +: COORD_W];
         if (expected_tracks.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result acc=%0b anc=%0b x=%0d y=%0d", $time,
                     seen.accepted, seen.anchor_reset, seen.smooth_x, seen.smooth_y);
         end else begin
            want = expected_tracks.pop_front();
            if (seen !== want) begin
               error_count++;
               $display("%0t: expected acc=%0b anc=%0b x=%0d y=%0d, got acc=%0b anc=%0b x=%0d y=%0d",
                        $time, want.accepted, want.anchor_reset, want.smooth_x, want.smooth_y,
                        seen.accepted, seen.anchor_reset, seen.smooth_x, seen.smooth_y);
            end
         end
      end
   end

   function automatic int manhattan(input logic [COORD_W-1:0] ax, ay, bx, by);
      int dx;
      int dy;
      dx = int'(ax) - int'(bx);
      dy = int'(ay) - int'(by);
      return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
   endfunction

   function automatic track_result_type predict_track(input logic [COORD_W-1:0] px, py);
      track_result_type r;
      int               drift;
      int               win;
      int               sum_x;
      int               sum_y;
      int               slot;
      r = '0;
      if (!has_point || manhattan(px, py, last_x, last_y) < int'(max_dist)) begin
         drift = manhattan(px, py, anchor_x, anchor_y);
         r.accepted = 1'b1;
         r.anchor_reset = !has_point || drift > int'(gpta_pkg::ANCHOR_SLACK);
         if (r.anchor_reset) begin
            anchor_x = px;
            anchor_y = py;
         end
         has_point = 1'b1;
         last_x = px;
         last_y = py;
         history[write_slot] = {py, px};
         write_slot = (write_slot + 1) % HISTORY_DEPTH;
         if (stored_count < HISTORY_DEPTH) begin
            stored_count++;
         end
      end
      win = int'(avg_window);
      if (win == 0) begin
         win = 1;
      end else if (win > HISTORY_DEPTH) begin
         win = HISTORY_DEPTH;
      end
      if (stored_count < win) begin
         r.smooth_x = last_x;
         r.smooth_y = last_y;
      end else begin
         sum_x = 0;
         sum_y = 0;
         for (int k = 0; k < win; k++) begin
            slot = (write_slot + HISTORY_DEPTH - 1 - k) % HISTORY_DEPTH;
            sum_x += int'(history[slot][COORD_W-1:0]);
            sum_y += int'(history[slot][2*COORD_W-1:COORD_W]);
         end
         r.smooth_x = COORD_W'(sum_x / win);
         r.smooth_y = COORD_W'(sum_y / win);
      end
      return r;
   endfunction

   task automatic send_point(input logic [COORD_W-1:0] px, py);
      track_result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {py, px};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      want = predict_track(px, py);
      expected_tracks = {expected_tracks, want};
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_tvalid = 1'b0;
      while (expected_tracks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] value);
      csr_index = idx;
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == gpta_pkg::REG_MAX_DIST) begin
         max_dist = value;
      end else begin
         avg_window = value[WIN_REG_W-1:0];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // The first point after reset, the distance gate at its boundary, the anchor
   // slack at its boundary, and a gate of zero.
   task automatic test_gate_and_anchor();
      send_point(12'd4095, 12'd0);
      send_point(12'd0, 12'd4095);
      send_point(12'd4093, 12'd2);
      send_point(12'd4088, 12'd2);
      send_point(12'd4078, 12'd1);
      send_point(12'd4078, 12'd20);
      send_point(12'd4078, 12'd40);
      send_point(12'd4081, 12'd22);
      wait_for_idle();
      write_register(gpta_pkg::REG_MAX_DIST, CSR_DAT_W'(0));
      send_point(12'd4081, 12'd22);
      send_point(12'd0, 12'd0);
   endtask

   // Window of zero, a full window, a window beyond the history depth, and the
   // narrowest gate that still accepts a repeated point.
   task automatic test_window_limits();
      wait_for_idle();
      write_register(gpta_pkg::REG_MAX_DIST, CSR_DAT_W'(8191));
      write_register(gpta_pkg::REG_AVG_WINDOW, CSR_DAT_W'(0));
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      wait_for_idle();
      write_register(gpta_pkg::REG_AVG_WINDOW, CSR_DAT_W'(16));
      repeat (8) send_point(12'd4095, 12'd4095);
      wait_for_idle();
      write_register(gpta_pkg::REG_AVG_WINDOW, CSR_DAT_W'(31));
      send_point(12'd4094, 12'd4095);
      wait_for_idle();
      write_register(gpta_pkg::REG_MAX_DIST, CSR_DAT_W'(1));
      write_register(gpta_pkg::REG_AVG_WINDOW, CSR_DAT_W'(1));
      send_point(12'd4094, 12'd4095);
      send_point(12'd4095, 12'd4095);
   endtask

   // Mostly tracks that wander near the last point, with small steps around the
   // anchor slack, mixed with jumps to random points that the gate rejects if too far.
   task automatic test_random_tracks(input int idle_pct, input int stall_pct);
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      int                 reach;
      int                 nx;
      int                 ny;
      wait_for_idle();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int seg = 0; seg < 3; seg++) begin
         wait_for_idle();
         unique case (seg)
            0: begin
               write_register(gpta_pkg::REG_MAX_DIST, CSR_DAT_W'(8191));
            end
            1: begin
               write_register(gpta_pkg::REG_MAX_DIST, CSR_DAT_W'($urandom_range(8, 400)));
            end
            default: begin
               write_register(gpta_pkg::REG_MAX_DIST, CSR_DAT_W'($urandom_range(1, 40)));
            end
         endcase
         write_register(gpta_pkg::REG_AVG_WINDOW, CSR_DAT_W'($urandom_range(0, 31)));
         repeat (SEGMENT_POINTS) begin
            if ($urandom_range(99) < 15) begin
               px = COORD_W'($urandom);
               py = COORD_W'($urandom);
            end else begin
               if ($urandom_range(99) < 35) begin
                  reach = 6;
               end else begin
                  reach = (max_dist > 1200) ? 600 : int'(max_dist) / 2 + 1;
               end
               nx = int'(last_x) + int'($urandom_range(0, 2 * reach)) - reach;
               ny = int'(last_y) + int'($urandom_range(0, 2 * reach)) - reach;
               nx = (nx < 0) ? 0 : ((nx > COORD_MAX) ? COORD_MAX : nx);
               ny = (ny < 0) ? 0 : ((ny > COORD_MAX) ? COORD_MAX : ny);
               px = COORD_W'(nx);
               py = COORD_W'(ny);
            end
            send_point(px, py);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      cycle_count = 0;
      has_point = 1'b0;
      last_x = '0;
      last_y = '0;
      anchor_x = '0;
      anchor_y = '0;
      write_slot = 0;
      stored_count = 0;
      max_dist = gpta_pkg::MAX_DIST_RESET;
      avg_window = gpta_pkg::AVG_WINDOW_RESET;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_gate_and_anchor();
      test_window_limits();
      test_random_tracks(0, 0);
      test_random_tracks(56, 0);
      test_random_tracks(0, 56);
      test_random_tracks(23, 23);

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
